@@ rtl/lod_chain_crossfade_controller_top_defines.svh @@
// ----------------------------------------------------------------------------
// LOD chain crossfade controller assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef LOD_CHAIN_CROSSFADE_CONTROLLER_TOP_DEFINES_SVH
`define LOD_CHAIN_CROSSFADE_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define LCCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lccc_pkg.sv @@
// ----------------------------------------------------------------------------
// LOD chain crossfade controller package
// Payload types, command and operation codes, shared helpers.
// ----------------------------------------------------------------------------
package lccc_pkg;

    localparam int LW = 4;
    localparam int FW = 17;
    localparam logic [FW-1:0] FADE_ONE = 17'h10000;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_INIT   = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_UPDATE = 2'd3;

    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_CAPTURE = 4'd1;
    localparam logic [3:0] OP_EXEC    = 4'd2;
    localparam logic [3:0] OP_LOAD    = 4'd3;
    localparam logic [3:0] OP_WALK    = 4'd4;
    localparam logic [3:0] OP_FINAL   = 4'd5;
    localparam logic [3:0] OP_CHANGE  = 4'd6;
    localparam logic [3:0] OP_LOOP    = 4'd7;
    localparam logic [3:0] OP_RAMP    = 4'd8;
    localparam logic [3:0] OP_RAMP2   = 4'd9;
    localparam logic [3:0] OP_DONE    = 4'd10;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  chain_id;
        logic [7:0]  table_index;
        logic [23:0] threshold;
        logic [7:0]  first_lod;
        logic [3:0]  lod_count;
        logic [23:0] far_dist;
        logic [23:0] cam_dist;
        logic [31:0] cur_time;
    } t_in;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] lod_index;
        logic [7:0] fade_byte;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [3:0] op;
        logic       force_dt;
    } t_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       lod_en;
        logic       walk_more;
        logic       lvl_same;
        logic       fading;
        logic       big_jump;
        logic       loop_more;
        logic       ramp_two;
        logic       out_free;
    } t_stat;

    function automatic logic [7:0] mod_reduce(input logic [7:0] v, input int m);
        logic [20:0] rem;
        int k;
        rem = {13'd0, v};
        for (k = 7; k >= 0; k--) begin
            if (rem >= (21'(m) << k)) begin
                rem = rem - (21'(m) << k);
            end
        end
        return rem[7:0];
    endfunction

    function automatic logic [7:0] fade_to_byte(input logic [FW-1:0] f);
        logic [FW+7:0] p;
        p = {8'd0, f} * 25'd255;
        return p[23:16];
    endfunction

endpackage

@@ rtl/lccc_ctrl.sv @@
// ----------------------------------------------------------------------------
// LOD chain crossfade controller sequencer
// Steps each update through walk, level change, ramp and flush; other commands take shorter paths.
// ----------------------------------------------------------------------------
module lccc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lccc_pkg::t_stat i_stat,
    output lccc_pkg::t_ctl  o_ctl
);
    import lccc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_WWAIT = 4'd4;
    localparam logic [3:0] S_FINAL = 4'd5;
    localparam logic [3:0] S_CL0   = 4'd6;
    localparam logic [3:0] S_CL1   = 4'd7;
    localparam logic [3:0] S_LOOP  = 4'd8;
    localparam logic [3:0] S_RAMP  = 4'd9;
    localparam logic [3:0] S_RAMP2 = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_force, n_force;

    always_comb begin
        n_state    = r_state;
        n_force    = r_force;
        o_ctl.op   = OP_NONE;
        o_ctl.force_dt = r_force;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.op = OP_CAPTURE;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.cmd == CMD_UPDATE) begin
                    n_state = S_LOAD;
                end else begin
                    o_ctl.op = OP_EXEC;
                    n_state  = (i_stat.cmd == CMD_INIT) ? S_LOOP : S_DONE;
                end
            end
            S_LOAD: begin
                o_ctl.op = OP_LOAD;
                n_state  = i_stat.lod_en ? S_WALK : S_FINAL;
            end
            S_WALK: begin
                if (i_stat.walk_more) begin
                    o_ctl.op = OP_WALK;
                    n_state  = S_WWAIT;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_WWAIT: begin
                n_state = S_WALK;
            end
            S_FINAL: begin
                o_ctl.op = OP_FINAL;
                n_state  = S_CL0;
            end
            S_CL0: begin
                if (i_stat.lvl_same) begin
                    n_force = 1'b0;
                    n_state = S_RAMP;
                end else if (i_stat.fading) begin
                    n_force = 1'b1;
                    n_state = S_RAMP;
                end else begin
                    n_state = S_CL1;
                end
            end
            S_CL1: begin
                if (i_stat.out_free) begin
                    o_ctl.op = OP_CHANGE;
                    n_force  = 1'b0;
                    n_state  = i_stat.big_jump ? S_LOOP : S_RAMP;
                end
            end
            S_LOOP: begin
                if (!i_stat.loop_more) begin
                    n_force = 1'b0;
                    n_state = (i_stat.cmd == CMD_INIT) ? S_DONE : S_RAMP;
                end else if (i_stat.out_free) begin
                    o_ctl.op = OP_LOOP;
                end
            end
            S_RAMP: begin
                if (i_stat.out_free) begin
                    o_ctl.op = OP_RAMP;
                    if (i_stat.ramp_two) begin
                        n_state = S_RAMP2;
                    end else begin
                        n_state = r_force ? S_CL1 : S_DONE;
                    end
                end
            end
            S_RAMP2: begin
                if (i_stat.out_free) begin
                    o_ctl.op = OP_RAMP2;
                    n_state  = r_force ? S_CL1 : S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.op = OP_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_force <= 1'b0;
        end else begin
            r_state <= n_state;
            r_force <= n_force;
        end
    end

endmodule

@@ rtl/lccc_datapath.sv @@
// ----------------------------------------------------------------------------
// LOD chain crossfade controller datapath
// Threshold and chain memories, level and fade arithmetic, write staging.
// ----------------------------------------------------------------------------
module lccc_datapath #(
    parameter int MAX_CHAINS      = 256,
    parameter int MAX_LOD_ENTRIES = 256,
    parameter int MAX_LEVELS      = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  lccc_pkg::t_in   i_in_data,
    input  lccc_pkg::t_ctl  i_ctl,
    output lccc_pkg::t_stat o_stat,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output lccc_pkg::t_out  o_out_data
);
    import lccc_pkg::*;

    localparam int CAW = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
    localparam int TAW = $clog2(MAX_LOD_ENTRIES);
    localparam int CDW = 2 * LW + FW;

    logic [23:0]    r_tmem [MAX_LOD_ENTRIES];
    logic [CDW-1:0] r_cmem [MAX_CHAINS];
    logic [23:0]    r_tdata;
    logic [CDW-1:0] r_cdata;

    logic [1:0]     r_cmd;
    logic [CAW-1:0] r_chain;
    logic [TAW-1:0] r_taddr;
    logic [23:0]    r_thr, r_far, r_cam;
    logic [7:0]     r_first;
    logic [LW-1:0]  r_count;
    logic [31:0]    r_now, r_last_time;
    logic           r_seen, r_lod_en;
    logic [FW-1:0]  r_frame_dt, r_fade;
    logic [LW-1:0]  r_cur, r_prev, r_lvl, r_i;

    logic           r_hold_v;
    logic [7:0]     r_hold_idx, r_hold_byte;
    logic           r_out_v;
    t_out           r_out;

    logic [LW-1:0]  w_count, w_top, w_diff;
    logic [32:0]    w_tdiff;
    logic [FW-1:0]  w_tick_dt;
    logic           w_pin, w_cin, w_up, w_sat_up, w_sat_dn, w_sat, w_big;
    logic [FW:0]    w_sum;
    logic [FW-1:0]  n_fade;
    logic [7:0]     w_ramp_idx, w_ramp_prev_idx, w_ramp_cur_idx, w_edge_idx;
    logic [FW-1:0]  w_ramp_fade;
    logic           w_emit;
    logic [7:0]     w_emit_idx;
    logic [FW-1:0]  w_emit_fade;
    logic [7:0]     w_rd_sel;

    assign w_count = (i_in_data.lod_count > LW'(MAX_LEVELS)) ? LW'(MAX_LEVELS)
                                                             : i_in_data.lod_count;
    assign w_rd_sel = (i_in_data.command == CMD_LOAD) ? i_in_data.table_index
                                                      : i_in_data.first_lod;
    assign w_top   = r_count + LW'(1);

    assign w_tdiff = {1'b0, r_now} - {1'b0, r_last_time};
    always_comb begin
        if (!r_seen || (!w_tdiff[32] && (w_tdiff[31:0] > 32'(FADE_ONE)))) begin
            w_tick_dt = FADE_ONE;
        end else if (w_tdiff[32]) begin
            w_tick_dt = '0;
        end else begin
            w_tick_dt = w_tdiff[FW-1:0];
        end
    end

    assign w_diff = (r_lvl > r_cur) ? (r_lvl - r_cur) : (r_cur - r_lvl);
    assign w_big  = w_diff > LW'(1);

    assign w_pin    = (r_prev != '0) && (r_prev != w_top);
    assign w_cin    = (r_cur != '0) && (r_cur != w_top);
    assign w_up     = !w_pin || (w_cin && (r_cur > r_prev));
    assign w_sum    = {1'b0, r_fade} + {1'b0, r_frame_dt};
    assign w_sat_up = i_ctl.force_dt || (w_sum >= {1'b0, FADE_ONE});
    assign w_sat_dn = i_ctl.force_dt || (r_fade <= r_frame_dt);
    assign w_sat    = w_up ? w_sat_up : w_sat_dn;
    always_comb begin
        if (w_up) begin
            n_fade = w_sat_up ? FADE_ONE : w_sum[FW-1:0];
        end else begin
            n_fade = w_sat_dn ? '0 : (r_fade - r_frame_dt);
        end
    end

    assign w_ramp_prev_idx = r_first + 8'(r_prev) - 8'd1;
    assign w_ramp_cur_idx  = r_first + 8'(r_cur) - 8'd1;
    assign w_edge_idx      = r_first + 8'(r_count) - 8'd1;
    always_comb begin
        w_ramp_fade = n_fade;
        if (w_pin && w_cin) begin
            if (r_cur > r_prev) begin
                w_ramp_idx = w_sat ? w_ramp_prev_idx : w_ramp_cur_idx;
                if (w_sat) begin
                    w_ramp_fade = '0;
                end
            end else begin
                w_ramp_idx = w_ramp_prev_idx;
            end
        end else if (w_pin) begin
            w_ramp_idx = (r_cur != '0) ? w_edge_idx : r_first;
        end else begin
            w_ramp_idx = (r_prev != '0) ? w_edge_idx : r_first;
        end
    end

    always_comb begin
        w_emit      = 1'b0;
        w_emit_idx  = '0;
        w_emit_fade = '0;
        case (i_ctl.op)
            OP_CHANGE: begin
                if (!w_big && (r_lvl < r_cur) && (r_cur != w_top) && (r_lvl != '0)) begin
                    w_emit      = 1'b1;
                    w_emit_idx  = r_first + 8'(r_lvl) - 8'd1;
                    w_emit_fade = FADE_ONE;
                end
            end
            OP_LOOP: begin
                w_emit = 1'b1;
                if (r_cmd == CMD_INIT) begin
                    w_emit_idx = r_first + 8'(r_i);
                end else begin
                    w_emit_idx  = r_first + 8'(r_i) - 8'd1;
                    w_emit_fade = (r_i == r_cur) ? FADE_ONE : '0;
                end
            end
            OP_RAMP: begin
                w_emit      = r_cur != r_prev;
                w_emit_idx  = w_ramp_idx;
                w_emit_fade = w_ramp_fade;
            end
            OP_RAMP2: begin
                w_emit      = 1'b1;
                w_emit_idx  = w_ramp_cur_idx;
                w_emit_fade = r_fade;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((i_ctl.op == OP_EXEC) && (r_cmd == CMD_LOAD)) begin
            r_tmem[r_taddr] <= r_thr;
        end
        r_tdata <= r_tmem[r_taddr];
    end

    always_ff @(posedge i_clk) begin
        if ((i_ctl.op == OP_DONE) && ((r_cmd == CMD_INIT) || (r_cmd == CMD_UPDATE))) begin
            r_cmem[r_chain] <= {r_cur, r_prev, r_fade};
        end
        r_cdata <= r_cmem[r_chain];
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_CAPTURE: begin
                r_cmd   <= i_in_data.command;
                r_chain <= CAW'(mod_reduce(i_in_data.chain_id, MAX_CHAINS));
                r_taddr <= TAW'(mod_reduce(w_rd_sel, MAX_LOD_ENTRIES));
                r_thr   <= i_in_data.threshold;
                r_first <= i_in_data.first_lod;
                r_count <= w_count;
                r_far   <= i_in_data.far_dist;
                r_cam   <= i_in_data.cam_dist;
                r_now   <= i_in_data.cur_time;
            end
            OP_EXEC: begin
                if (r_cmd == CMD_INIT) begin
                    r_cur  <= LW'(1);
                    r_prev <= LW'(1);
                    r_fade <= '0;
                    r_i    <= LW'(1);
                end
            end
            OP_LOAD: begin
                {r_cur, r_prev, r_fade} <= r_cdata;
                r_lvl <= '0;
            end
            OP_WALK: begin
                r_lvl   <= r_lvl + LW'(1);
                r_taddr <= (r_taddr == TAW'(MAX_LOD_ENTRIES - 1)) ? '0 : r_taddr + TAW'(1);
            end
            OP_FINAL: begin
                if (r_lod_en) begin
                    r_lvl <= r_lvl + LW'(r_cam > r_far);
                end else begin
                    r_lvl <= LW'(1);
                end
            end
            OP_CHANGE: begin
                r_cur <= r_lvl;
                if (w_big) begin
                    r_prev <= r_lvl;
                    r_i    <= LW'(1);
                end else begin
                    r_prev <= r_cur;
                    if (r_lvl < r_cur) begin
                        r_fade <= (r_cur == w_top) ? '0 : FADE_ONE;
                    end else begin
                        r_fade <= (r_lvl == w_top) ? FADE_ONE : '0;
                    end
                end
            end
            OP_LOOP: begin
                r_i <= r_i + LW'(1);
            end
            OP_RAMP: begin
                if (r_cur != r_prev) begin
                    r_fade <= n_fade;
                    if (w_sat) begin
                        r_prev <= r_cur;
                    end
                end
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lod_en    <= 1'b1;
            r_seen      <= 1'b0;
            r_last_time <= '0;
            r_frame_dt  <= FADE_ONE;
        end else begin
            if (i_cfg_we) begin
                r_lod_en <= i_cfg_wdata;
            end
            if ((i_ctl.op == OP_EXEC) && (r_cmd == CMD_TICK)) begin
                r_frame_dt  <= w_tick_dt;
                r_last_time <= r_now;
                r_seen      <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (i_ctl.op == OP_DONE) begin
            r_out_v  <= 1'b1;
            r_hold_v <= 1'b0;
            if (r_hold_v) begin
                r_out <= '{write_valid: 1'b1, lod_index: r_hold_idx,
                           fade_byte: r_hold_byte, last: 1'b1};
            end else begin
                r_out <= '{write_valid: 1'b0, lod_index: 8'd0,
                           fade_byte: 8'd0, last: 1'b1};
            end
        end else if (w_emit) begin
            if (r_hold_v) begin
                r_out_v <= 1'b1;
                r_out   <= '{write_valid: 1'b1, lod_index: r_hold_idx,
                             fade_byte: r_hold_byte, last: 1'b0};
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            r_hold_v    <= 1'b1;
            r_hold_idx  <= w_emit_idx;
            r_hold_byte <= fade_to_byte(w_emit_fade);
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    assign o_stat.cmd       = r_cmd;
    assign o_stat.lod_en    = r_lod_en;
    assign o_stat.walk_more = (r_lvl < r_count) && (r_cam > r_tdata);
    assign o_stat.lvl_same  = r_lvl == r_cur;
    assign o_stat.fading    = r_prev != r_cur;
    assign o_stat.big_jump  = w_big;
    assign o_stat.loop_more = r_i < r_count;
    assign o_stat.ramp_two  = w_pin && w_cin && (r_cur > r_prev) && w_sat_up;
    assign o_stat.out_free  = !r_out_v || i_out_ready;

endmodule

@@ rtl/lod_chain_crossfade_controller_top.sv @@
// Accept to completion transfer: load and tick go straight to their completion; init
// adds its fade writes; update walks the thresholds passed, may finish a pending fade,
// changes level with the fade writes of a multi-level jump, then ramps the fade.
// Throughput: one item in flight, the next is taken once its completion is staged;
// output stalls hold the sequence. Synchronous active-low reset clears control and
// frame timing and sets lod_enable; threshold and chain memories hold until written.
// ----------------------------------------------------------------------------
// LOD chain crossfade controller top level
// Sequencer plus datapath for level selection and fade ramp writes.
// ----------------------------------------------------------------------------
module lod_chain_crossfade_controller_top #(
    parameter int MAX_CHAINS      = 256,
    parameter int MAX_LOD_ENTRIES = 256,
    parameter int MAX_LEVELS      = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lccc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lccc_pkg::t_out o_out_data
);
    import lccc_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;

    lccc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    lccc_datapath #(
        .MAX_CHAINS      (MAX_CHAINS),
        .MAX_LOD_ENTRIES (MAX_LOD_ENTRIES),
        .MAX_LEVELS      (MAX_LEVELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/lccc_checker.sv @@
// ----------------------------------------------------------------------------
// LOD chain crossfade controller port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "lod_chain_crossfade_controller_top_defines.svh"

module lccc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input lccc_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input lccc_pkg::t_out o_out_data
);
    import lccc_pkg::*;

    `LCCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")
    `LCCC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_data), "input dropped or changed while waiting")
    `LCCC_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second item taken before completion")
    `LCCC_ASSERT_SAME(a_empty_done, i_clk, i_rst_n, o_out_valid && !o_out_data.write_valid, o_out_data.last && (o_out_data.lod_index == 8'd0) && (o_out_data.fade_byte == 8'd0), "malformed empty completion")

endmodule

bind lod_chain_crossfade_controller_top lccc_checker u_lccc_checker (.*);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// LOD chain crossfade controller testbench
// Drives load, init, frame tick and update commands through the valid/ready
// input channel and checks every fade write and empty completion against a
// local prediction of the threshold walk, level change and fade ramp rules.
// It runs under several idle and stall patterns, with both lod_enable
// settings, and with one long output hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_top;
    import lccc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    lod_chain_crossfade_controller_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    localparam int ONE_Q16 = 65536;
    localparam int FORCED_DT = 1000 * 65536;
    localparam int WRITE_CAP = 12;

    // predicted block state
    logic [23:0] thr_mem [256];
    int          cur_lv [256];
    int          prv_lv [256];
    int          fade_q16 [256];
    logic [31:0] prev_time = '0;
    bit          tick_seen = 1'b0;
    int          dt_q16 = ONE_Q16;
    bit          lod_en = 1'b1;

    t_out fade_buf [WRITE_CAP];
    int   fade_n;
    t_out fade_q [$];

    // stimulus bookkeeping
    bit   thr_loaded [256];
    bit   chain_live [256];
    int   chain_first [256];
    int   chain_cnt [256];
    int   live_ids [$];
    logic [31:0] gen_time = '0;

    int idle_mode = 0;      // 0 none, 1 sender, 2 receiver, 3 both
    int hold_cycles = 0;
    int err_cnt = 0;
    int n_sent = 0;
    int n_writes = 0;
    int n_results = 0;

    function automatic void push_fade(int idx, int f);
        longint p;
        if (fade_n < WRITE_CAP) begin
            p = (longint'(f) * 255) >>> 16;
            fade_buf[fade_n] = '{1'b1, 8'(idx), 8'(p), 1'b0};
            fade_n++;
        end
    endfunction

    function automatic void ramp_fade(int c, int dt, int first, int cnt);
        int cur, prv, top, f, idx;
        cur = cur_lv[c];
        prv = prv_lv[c];
        top = cnt + 1;
        f = fade_q16[c];
        if (cur == prv) return;
        if (prv != 0 && prv != top) begin
            if (cur != 0 && cur != top) begin
                if (cur <= prv) begin
                    f -= dt;
                    if (f <= 0) begin
                        f = 0;
                        prv_lv[c] = cur;
                    end
                    fade_q16[c] = f;
                    push_fade(first + prv - 1, f);
                end else begin
                    f += dt;
                    if (f >= ONE_Q16) begin
                        f = ONE_Q16;
                        prv_lv[c] = cur;
                    end
                    fade_q16[c] = f;
                    if (f >= ONE_Q16) push_fade(first + prv - 1, 0);
                    push_fade(first + cur - 1, f);
                end
            end else begin
                idx = (cur != 0) ? first + cnt - 1 : first;
                f -= dt;
                if (f <= 0) begin
                    f = 0;
                    prv_lv[c] = cur;
                end
                fade_q16[c] = f;
                push_fade(idx, f);
            end
        end else begin
            idx = (prv != 0) ? first + cnt - 1 : first;
            f += dt;
            if (f >= ONE_Q16) begin
                f = ONE_Q16;
                prv_lv[c] = cur;
            end
            fade_q16[c] = f;
            push_fade(idx, f);
        end
    endfunction

    function automatic void shift_level(int c, int lvl, int first, int cnt);
        int cur, prv, diff;
        if (lvl == cur_lv[c]) return;
        if (prv_lv[c] != cur_lv[c]) ramp_fade(c, FORCED_DT, first, cnt);
        prv_lv[c] = cur_lv[c];
        cur_lv[c] = lvl;
        cur = lvl;
        prv = prv_lv[c];
        diff = (cur > prv) ? cur - prv : prv - cur;
        if (diff <= 1) begin
            if (cur <= prv) begin
                if (prv == cnt + 1) begin
                    fade_q16[c] = 0;
                end else begin
                    fade_q16[c] = ONE_Q16;
                    if (cur != 0) push_fade(first + cur - 1, ONE_Q16);
                end
            end else begin
                fade_q16[c] = (cur == cnt + 1) ? ONE_Q16 : 0;
            end
        end else begin
            for (int i = 1; i < cnt; i++) push_fade(first + i - 1, (i == cur) ? ONE_Q16 : 0);
            prv_lv[c] = cur;
        end
    endfunction

    function automatic void predict_fades(t_in it);
        int c, first, cnt, lvl;
        longint d;
        c = it.chain_id;
        first = it.first_lod;
        cnt = (it.lod_count > 8) ? 8 : it.lod_count;
        fade_n = 0;
        case (it.command)
            CMD_LOAD: begin
                thr_mem[it.table_index] = it.threshold;
            end
            CMD_INIT: begin
                cur_lv[c] = 1;
                prv_lv[c] = 1;
                fade_q16[c] = 0;
                for (int i = 1; i < cnt; i++) push_fade(first + i, 0);
            end
            CMD_TICK: begin
                if (!tick_seen) begin
                    dt_q16 = ONE_Q16;
                end else begin
                    d = longint'(it.cur_time) - longint'(prev_time);
                    if (d < 0) d = 0;
                    if (d > ONE_Q16) d = ONE_Q16;
                    dt_q16 = int'(d);
                end
                prev_time = it.cur_time;
                tick_seen = 1'b1;
            end
            default: begin
                lvl = 0;
                if (lod_en) begin
                    while (lvl < cnt && it.cam_dist > thr_mem[8'(first + lvl)]) lvl++;
                    if (it.cam_dist > it.far_dist) lvl++;
                end else begin
                    lvl = 1;
                end
                shift_level(c, lvl, first, cnt);
                ramp_fade(c, dt_q16, first, cnt);
            end
        endcase
        if (fade_n == 0) begin
            fade_q.push_back('{1'b0, 8'd0, 8'd0, 1'b1});
        end else begin
            fade_buf[fade_n-1].last = 1'b1;
            for (int i = 0; i < fade_n; i++) fade_q.push_back(fade_buf[i]);
        end
    endfunction

    function automatic bit idle_now(bit receiver);
        int pct;
        pct = 0;
        if (idle_mode == 3) pct = 8;
        else if (idle_mode == 1 && !receiver) pct = 85;
        else if (idle_mode == 2 && receiver) pct = 85;
        return ($urandom_range(0, 99) < pct);
    endfunction

    // output side: check each transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (fade_q.size() == 0) begin
                    $error("unexpected result %p", o_out_data);
                    err_cnt++;
                end else begin
                    t_out e;
                    e = fade_q.pop_front();
                    if (e.write_valid) n_writes++;
                    if (o_out_data.write_valid !== e.write_valid) begin
                        $error("write_valid exp %0d got %0d", e.write_valid,
                               o_out_data.write_valid);
                        err_cnt++;
                    end
                    if (o_out_data.lod_index !== e.lod_index) begin
                        $error("lod_index exp %0d got %0d", e.lod_index,
                               o_out_data.lod_index);
                        err_cnt++;
                    end
                    if (o_out_data.fade_byte !== e.fade_byte) begin
                        $error("fade_byte exp %0d got %0d", e.fade_byte,
                               o_out_data.fade_byte);
                        err_cnt++;
                    end
                    if (o_out_data.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, o_out_data.last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // output side: count down a hold-off, else pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !idle_now(1'b1);
            end
        end
    end

    task automatic send_item(t_in it);
        int gap;
        gap = 0;
        while (idle_now(1'b0)) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_fades(it);
        n_sent++;
    endtask

    task automatic drain_all();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (fade_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_lod_enable(bit v);
        drain_all();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lod_en = v;
    endtask

    function automatic t_in make_cmd(logic [1:0] cmd);
        t_in it;
        it = '0;
        it.command = cmd;
        return it;
    endfunction

    task automatic load_thr(int idx, logic [23:0] v);
        t_in it;
        it = make_cmd(CMD_LOAD);
        it.table_index = 8'(idx);
        it.threshold = v;
        send_item(it);
        thr_loaded[8'(idx)] = 1'b1;
    endtask

    task automatic init_chain(int c, int first, int cnt);
        t_in it;
        it = make_cmd(CMD_INIT);
        it.chain_id = 8'(c);
        it.first_lod = 8'(first);
        it.lod_count = 4'(cnt);
        send_item(it);
        if (!chain_live[c]) live_ids.push_back(c);
        chain_live[c] = 1'b1;
        chain_first[c] = first;
        chain_cnt[c] = cnt;
    endtask

    task automatic tick(logic [31:0] t);
        t_in it;
        it = make_cmd(CMD_TICK);
        it.cur_time = t;
        send_item(it);
        gen_time = t;
    endtask

    task automatic update_chain(int c, logic [23:0] cam, logic [23:0] far);
        t_in it;
        it = make_cmd(CMD_UPDATE);
        it.chain_id = 8'(c);
        it.first_lod = 8'(chain_first[c]);
        it.lod_count = 4'(chain_cnt[c]);
        it.cam_dist = cam;
        it.far_dist = far;
        // other fields carry noise; the block must ignore them
        it.table_index = 8'($urandom);
        it.threshold = 24'($urandom);
        it.cur_time = $urandom;
        send_item(it);
    endtask

    task automatic test_directed();
        for (int i = 0; i < 8; i++) load_thr(i, 24'((i + 1) * 100));
        load_thr(254, 24'd0);
        load_thr(255, 24'hFFFFFF);
        init_chain(0, 0, 8);
        init_chain(255, 254, 3);
        init_chain(7, 0, 0);
        init_chain(9, 0, 15);
        tick(32'hFFFFFFFF);
        update_chain(0, 24'd0, 24'hFFFFFF);
        update_chain(0, 24'hFFFFFF, 24'd0);
        update_chain(0, 24'd350, 24'hFFFFFF);
        tick(32'd0);
        tick(32'h8000);
        update_chain(0, 24'd250, 24'hFFFFFF);
        update_chain(0, 24'd250, 24'hFFFFFF);
        tick(32'h28000);
        update_chain(0, 24'd450, 24'hFFFFFF);
        update_chain(255, 24'd1, 24'd0);
        update_chain(7, 24'd5, 24'd0);
        update_chain(9, 24'hFFFFFF, 24'd0);
        update_chain(9, 24'd150, 24'hFFFFFF);
    endtask

    task automatic random_item();
        int r, c, first, cnt;
        logic [31:0] t;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            if ($urandom_range(0, 3) == 0) load_thr($urandom_range(0, 255), 24'($urandom));
            else load_thr($urandom_range(0, 255), 24'($urandom_range(0, 2000)));
        end else if (r < 18 || live_ids.size() == 0) begin
            c = $urandom_range(0, 255);
            first = $urandom_range(0, 255);
            cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            for (int i = 0; i < ((cnt > 8) ? 8 : cnt); i++)
                if (!thr_loaded[8'(first + i)])
                    load_thr(first + i, 24'(200 * i + $urandom_range(0, 250)));
            init_chain(c, first, cnt);
        end else if (r < 34) begin
            case ($urandom_range(0, 9))
                0: t = $urandom;
                1: t = gen_time - $urandom_range(0, 4000);
                default: t = gen_time + $urandom_range(0, 32'h14000);
            endcase
            tick(t);
        end else begin
            c = live_ids[$urandom_range(0, live_ids.size() - 1)];
            if ($urandom_range(0, 7) == 0)
                update_chain(c, 24'($urandom), 24'($urandom));
            else
                update_chain(c, 24'($urandom_range(0, 2000)),
                             24'($urandom_range(800, 2400)));
        end
    endtask

    task automatic test_random_phase(int mode, int n);
        idle_mode = mode;
        for (int i = 0; i < n; i++) random_item();
        drain_all();
    endtask

    task automatic test_lod_off();
        set_lod_enable(1'b0);
        for (int i = 0; i < 15; i++) random_item();
        set_lod_enable(1'b1);
    endtask

    task automatic test_backpressure();
        idle_mode = 0;
        drain_all();
        hold_cycles = 600;
        for (int i = 0; i < 30; i++) random_item();
        drain_all();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain_all();
        test_lod_off();
        test_backpressure();
        test_random_phase(0, 70);
        set_lod_enable(1'b0);
        test_random_phase(1, 25);
        set_lod_enable(1'b1);
        test_random_phase(1, 50);
        test_random_phase(2, 70);
        set_lod_enable(1'b0);
        test_random_phase(3, 20);
        set_lod_enable(1'b1);
        test_random_phase(3, 50);
        drain_all();
        $display("covered %0d items, %0d results, %0d fade writes, %0d chains live",
                 n_sent, n_results, n_writes, live_ids.size());
        $display("under four idle patterns, both lod_enable values and a long hold-off");
        if (err_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
